// ===== rtl/core/cls_pkg.sv =====
// Package for the coordinate list sorter: item types, cell control and state codes.
// Used by the sort cell, the top level and the testbench.
`default_nettype none
package cls_pkg;

	localparam int unsigned DEF_CAPACITY = 32;

	typedef struct packed {
		logic [15:0]        row_index;
		logic [15:0]        col_index;
		logic signed [31:0] entry_value;
		logic               last_entry;
	} cls_in_t;

	typedef struct packed {
		logic [15:0]        out_row;
		logic [15:0]        out_col;
		logic signed [31:0] out_value;
		logic               out_last;
		logic               overflow;
	} cls_res_t;

	typedef struct packed {
		logic [15:0]        row_index;
		logic [15:0]        col_index;
		logic signed [31:0] entry_value;
	} cls_entry_t;

	typedef struct packed {
		logic load;
		logic sort;
		logic shift;
		logic mode;
	} cls_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_DRAIN
	} cls_state_t;

	localparam logic MODE_ROW_MAJOR = 1'b0;

	// Compound key: row then column, or column then row.
	function automatic logic [31:0] key_of(input cls_entry_t e, input logic mode);
		logic [31:0] k;
		if (mode == MODE_ROW_MAJOR) begin
			k = {e.row_index, e.col_index};
		end else begin
			k = {e.col_index, e.row_index};
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cls_chan_if.sv =====
// Valid/ready channel carrying one item of payload type T.
// Depends on nothing; payload types come from cls_pkg at the point of use.
`default_nettype none
interface cls_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/coordinate_list_sorter.sv =====
// Coordinate list sorter: collects (row, col, value) entries into a chain of cells, one entry
// per cycle, and on the entry marked last sorts them by (row, col) or (col, row) with an
// odd-even transposition pass over neighboring cells, stable for equal keys. A list is
// loaded, then sorted in compare-exchange phases across the chain, then drained as one
// result item per cycle while the sink is ready. No new entry is taken from the last entry
// until the final result item is delivered. Entries beyond CAPACITY are dropped and flag
// overflow on every result of that list. sort_mode is sampled when the last entry arrives.
// Depends on cls_pkg, cls_chan_if and cls_cell.
`default_nettype none
module coordinate_list_sorter
	import cls_pkg::*;
#(
	parameter int unsigned CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	cls_chan_if.sink   cfg,
	cls_chan_if.sink   entries,
	cls_chan_if.source results
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	cls_state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] phase_q;
	logic          dropped_q;
	logic          mode_q;
	logic          sort_mode_q;

	cls_ctl_t   ctl;
	cls_entry_t new_entry;
	cls_entry_t cell_q [CAPACITY];
	logic       swap_w [CAPACITY];

	logic in_acc, out_acc, full, sort_done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_mode_q <= MODE_ROW_MAJOR;
		end else if (cfg.valid) begin
			sort_mode_q <= cfg.data;
		end
	end

	assign in_acc    = entries.valid && entries.ready;
	assign out_acc   = results.valid && results.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign sort_done = (phase_q == count_q - CW'(1));

	assign new_entry.row_index   = entries.data.row_index;
	assign new_entry.col_index   = entries.data.col_index;
	assign new_entry.entry_value = entries.data.entry_value;

	always_comb begin
		state_d        = state_q;
		entries.ready  = 1'b0;
		results.valid  = 1'b0;
		ctl.load       = 1'b0;
		ctl.sort       = 1'b0;
		ctl.shift      = 1'b0;
		ctl.mode       = mode_q;
		case (state_q)
			ST_LOAD: begin
				entries.ready = 1'b1;
				ctl.load      = entries.valid && !full;
				if (entries.valid && entries.data.last_entry) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				ctl.sort = 1'b1;
				if (sort_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				results.valid = 1'b1;
				ctl.shift     = results.ready;
				if (results.ready && count_q == CW'(1)) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			phase_q   <= '0;
			dropped_q <= 1'b0;
			mode_q    <= MODE_ROW_MAJOR;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.shift) begin
				count_q <= count_q - CW'(1);
			end
			if (in_acc && full) begin
				dropped_q <= 1'b1;
			end else if (out_acc && count_q == CW'(1)) begin
				dropped_q <= 1'b0;
			end
			if (in_acc && entries.data.last_entry) begin
				mode_q <= sort_mode_q;
			end
			if (state_q == ST_SORT) begin
				phase_q <= phase_q + CW'(1);
			end else begin
				phase_q <= '0;
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic       wr_sel, pair_lo, swap_left;
		cls_entry_t left_entry, right_entry;

		assign wr_sel  = (count_q == CW'(i));
		// Even phases pair (0,1),(2,3)...; odd phases pair (1,2),(3,4)...
		assign pair_lo = ((i % 2) == int'(phase_q[0])) && (CW'(i + 1) < count_q);

		if (i == 0) begin : g_first
			assign swap_left  = 1'b0;
			assign left_entry = cell_q[i];
		end else begin : g_mid
			assign swap_left  = swap_w[i-1];
			assign left_entry = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_top
			assign right_entry = cell_q[i];
		end else begin : g_below
			assign right_entry = cell_q[i+1];
		end

		cls_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.wr_sel      (wr_sel),
			.pair_lo     (pair_lo),
			.swap_left   (swap_left),
			.new_entry   (new_entry),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry_q     (cell_q[i]),
			.swap_lo     (swap_w[i])
		);
	end

	assign results.data.out_row   = cell_q[0].row_index;
	assign results.data.out_col   = cell_q[0].col_index;
	assign results.data.out_value = cell_q[0].entry_value;
	assign results.data.out_last  = (count_q == CW'(1));
	assign results.data.overflow  = dropped_q;

	a_no_empty_drain: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (count_q != '0))
		else $error("result offered from an empty chain");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && entries.data.last_entry) |=> (state_q == ST_SORT && count_q != '0))
		else $error("last entry did not start a sort of a nonempty list");

	a_final_item_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && results.data.out_last) |=> (entries.ready && count_q == '0 && !dropped_q))
		else $error("list state not cleared after final item");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("entry lost while space remained");

endmodule
`default_nettype wire

// ===== rtl/core/cls_cell.sv =====
// One cell of the sorting chain: holds one entry, compares with its right neighbor.
// Depends on cls_pkg.
`default_nettype none
module cls_cell
	import cls_pkg::*;
(
	input  logic       clk,
	input  cls_ctl_t   ctl,
	input  logic       wr_sel,
	input  logic       pair_lo,
	input  logic       swap_left,
	input  cls_entry_t new_entry,
	input  cls_entry_t left_entry,
	input  cls_entry_t right_entry,
	output cls_entry_t entry_q,
	output logic       swap_lo
);

	// Swap only on strictly greater keys so equal keys keep arrival order.
	assign swap_lo = ctl.sort && pair_lo &&
		(key_of(entry_q, ctl.mode) > key_of(right_entry, ctl.mode));

	always_ff @(posedge clk) begin
		if (ctl.load && wr_sel) begin
			entry_q <= new_entry;
		end else if (swap_lo) begin
			entry_q <= right_entry;
		end else if (ctl.sort && swap_left) begin
			entry_q <= left_entry;
		end else if (ctl.shift) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb_coordinate_list_sorter.sv =====
`timescale 1ns / 100ps
// Testbench for coordinate_list_sorter: directed table, then random lists, scored by a
// stable-sort predictor of the result stream. Depends on cls_pkg, cls_chan_if and the RTL.
module tb_coordinate_list_sorter;
	import cls_pkg::*;

	localparam int unsigned CAPACITY = DEF_CAPACITY;
	localparam int ITEM_TARGET = 180;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES = 4 * CAPACITY;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_DIRECTED = 18;

	typedef enum logic {
		STEP_ENTRY,
		STEP_MODE
	} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		logic       mode_value;
		cls_in_t    item;
		logic       pinned;
		cls_res_t   result;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cls_chan_if #(.T(logic))     cfg_if ();
	cls_chan_if #(.T(cls_in_t))  entry_if ();
	cls_chan_if #(.T(cls_res_t)) result_if ();

	coordinate_list_sorter #(.CAPACITY(CAPACITY)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.entries (entry_if),
		.results (result_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	cls_entry_t held_entries[$];
	logic       entries_dropped;
	logic       sort_mode;
	cls_res_t   fresh_results[$];
	cls_res_t   sorted_due[$];

	// directed rows may pin their single result
	logic       use_pinned = 1'b0;
	cls_res_t   pinned_result;

	int mismatch_count = 0;
	int items_sent = 0;
	int lists_sent = 0;
	int results_checked = 0;
	int overflow_lists = 0;
	int mode_writes = 0;
	int cycle_count = 0;

	dir_step_t directed_steps [N_DIRECTED];

	function automatic logic [31:0] compound_key(input cls_entry_t e, input logic mode);
		if (mode == MODE_ROW_MAJOR)
			return {e.row_index, e.col_index};
		return {e.col_index, e.row_index};
	endfunction

	// Store one entry; on the last one, sort stably and emit the whole list.
	function void absorb_entry(input cls_in_t it);
		cls_entry_t cur;
		cls_res_t   r;
		int         j;
		fresh_results.delete();
		if (held_entries.size() < CAPACITY)
			held_entries.push_back('{it.row_index, it.col_index, it.entry_value});
		else
			entries_dropped = 1'b1;
		if (!it.last_entry)
			return;
		for (int i = 1; i < held_entries.size(); i++) begin
			cur = held_entries[i];
			j = i;
			while (j > 0 && compound_key(held_entries[j - 1], sort_mode) >
					compound_key(cur, sort_mode)) begin
				held_entries[j] = held_entries[j - 1];
				j--;
			end
			held_entries[j] = cur;
		end
		foreach (held_entries[k]) begin
			r.out_row   = held_entries[k].row_index;
			r.out_col   = held_entries[k].col_index;
			r.out_value = held_entries[k].entry_value;
			r.out_last  = (k == held_entries.size() - 1);
			r.overflow  = entries_dropped;
			fresh_results.push_back(r);
		end
		if (entries_dropped)
			overflow_lists++;
		held_entries.delete();
		entries_dropped = 1'b0;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_coord(input logic narrow);
		if (narrow)
			return 16'($urandom_range(0, 3));
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh80000000;
			1: return 32'sh7FFFFFFF;
			default: return 32'($urandom);
		endcase
	endfunction

	// Hold valid across back-to-back items; lower it only ahead of a gap.
	task automatic send_entry(input cls_in_t it);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			entry_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		entry_if.valid <= 1'b1;
		entry_if.data <= it;
		do @(posedge clk); while (!entry_if.ready);
		items_sent++;
		if (it.last_entry)
			lists_sent++;
		@(negedge clk);
	endtask

	// Called at a falling edge right after send_entry or write_sort_mode; leaves the block idle.
	task automatic wait_drained();
		entry_if.valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_sort_mode(input logic m);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= m;
		do @(posedge clk); while (!cfg_if.ready);
		sort_mode = m;
		mode_writes++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && entry_if.valid && entry_if.ready) begin
			absorb_entry(entry_if.data);
			if (use_pinned && entry_if.data.last_entry)
				sorted_due.push_back(pinned_result);
			else
				foreach (fresh_results[k])
					sorted_due.push_back(fresh_results[k]);
		end
	end

	always @(posedge clk) begin
		cls_res_t want;
		cls_res_t got;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = result_if.data;
			if (sorted_due.size() == 0) begin
				$error("result item with none expected: row %0d col %0d value %0d",
					got.out_row, got.out_col, got.out_value);
				mismatch_count++;
			end else begin
				want = sorted_due.pop_front();
				results_checked++;
				if (got.out_row !== want.out_row) begin
					$error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
					mismatch_count++;
				end
				if (got.out_col !== want.out_col) begin
					$error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
					mismatch_count++;
				end
				if (got.out_value !== want.out_value) begin
					$error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
					mismatch_count++;
				end
				if (got.out_last !== want.out_last) begin
					$error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
					mismatch_count++;
				end
				if (got.overflow !== want.overflow) begin
					$error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
					mismatch_count++;
				end
			end
		end
	end

	// result side: random stalls, mostly short, some long
	initial begin
		int stall_left;
		stall_left = 0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
		end
	end

	initial begin
		cls_in_t it;
		int      len;
		logic    narrow;
		cfg_if.valid = 1'b0;
		cfg_if.data = 1'b0;
		entry_if.valid = 1'b0;
		entry_if.data = '0;
		entries_dropped = 1'b0;
		sort_mode = MODE_ROW_MAJOR;

		directed_steps = '{
			// single entries: extremes come straight back, marked last
			'{STEP_ENTRY, 1'b0, '{16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 1'b1},
				1'b1, '{16'hFFFF, 16'hFFFF, 32'sh7FFFFFFF, 1'b1, 1'b0}},
			'{STEP_ENTRY, 1'b0, '{16'h0000, 16'h0000, 32'sh80000000, 1'b1},
				1'b1, '{16'h0000, 16'h0000, 32'sh80000000, 1'b1, 1'b0}},
			'{STEP_ENTRY, 1'b0, '{16'h0000, 16'hFFFF, 32'sh00000000, 1'b1},
				1'b1, '{16'h0000, 16'hFFFF, 32'sh00000000, 1'b1, 1'b0}},
			// row-major list with a repeated key
			'{STEP_ENTRY, 1'b0, '{16'h0005, 16'h0001, 32'sh0000000A, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0002, 16'h0007, 32'shFFFFFFFF, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0005, 16'h0000, 32'sh00000003, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0002, 16'h0007, 32'sh00000063, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0000, 16'hFFFF, 32'sh00000000, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h8000, 16'h0001, 32'sh12345678, 1'b1}, 1'b0, '0},
			'{STEP_MODE, 1'b1, '0, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'hA5A5, 16'h5A5A, 32'sh0000FFFF, 1'b1},
				1'b1, '{16'hA5A5, 16'h5A5A, 32'sh0000FFFF, 1'b1, 1'b0}},
			// column-major list: equal columns fall back to row, equal keys keep order
			'{STEP_ENTRY, 1'b0, '{16'h0003, 16'h0004, 32'sh00000001, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0001, 16'h0004, 32'sh00000002, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0003, 16'h0004, 32'sh00000003, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0000, 16'h0000, 32'shFFFFFFFB, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'hFFFF, 16'h0000, 32'sh00000006, 1'b0}, 1'b0, '0},
			'{STEP_ENTRY, 1'b0, '{16'h0001, 16'hFFFF, 32'sh80000000, 1'b1}, 1'b0, '0},
			'{STEP_MODE, 1'b0, '0, 1'b0, '0}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_steps[s]) begin
			if (directed_steps[s].kind == STEP_MODE) begin
				wait_drained();
				write_sort_mode(directed_steps[s].mode_value);
			end else begin
				use_pinned = directed_steps[s].pinned;
				pinned_result = directed_steps[s].result;
				send_entry(directed_steps[s].item);
			end
		end
		use_pinned = 1'b0;

		// Random lists: the first two fill the store exactly and overrun it by one.
		for (int l = 0; items_sent < ITEM_TARGET; l++) begin
			if (l == 0)
				len = CAPACITY;
			else if (l == 1)
				len = CAPACITY + 1;
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(CAPACITY - 2, CAPACITY + 8);
			else
				len = $urandom_range(1, 8);
			if ($urandom_range(0, 2) == 0) begin
				wait_drained();
				write_sort_mode(1'($urandom_range(0, 1)));
			end else if ($urandom_range(0, 3) == 0) begin
				wait_drained();
			end
			narrow = 1'($urandom_range(0, 1));
			for (int k = 0; k < len; k++) begin
				it.row_index = pick_coord(narrow);
				it.col_index = pick_coord(narrow);
				it.entry_value = pick_value();
				it.last_entry = (k == len - 1);
				send_entry(it);
			end
		end

		entry_if.valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sorted %0d lists from %0d entries, %0d of them overflowing, %0d mode writes;",
			lists_sent, items_sent, overflow_lists, mode_writes);
		$display("%0d result items checked, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0 && sorted_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/cls_pkg.sv
rtl/core/cls_chan_if.sv
rtl/core/cls_cell.sv
rtl/core/coordinate_list_sorter.sv
sim/tb_coordinate_list_sorter.sv
